>>> design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/fts_pkg.sv
// Shared constants, command codes and interface types of the frame time statistics core.
`default_nettype none
package fts_pkg;
   localparam int CAPACITY  = 1024;
   localparam int PTR_W     = 10;
   localparam int CNT_W     = 11;
   localparam int TIME_W    = 24;
   localparam int TOTAL_W   = 34;
   localparam int LIM_W     = 26;
   localparam int FPS_W     = 27;
   localparam int CFG_W     = 6;
   localparam int TOPN      = 11;
   localparam int TOP_IDX_W = 4;
   localparam int SLOW_W    = 28;
   localparam int RTOT_W    = 25;
   localparam int DIV_W     = 37;
   localparam int DIV_CNT_W = 6;
   localparam int OP_W      = 4;
   localparam int SEL_W     = 2;

   localparam logic [CFG_W-1:0]  CFG_RESET    = 6'd10;
   localparam logic [CFG_W-1:0]  CFG_MAX      = 6'd60;
   localparam logic [RTOT_W-1:0] RECENT_SPAN  = 25'd500000;
   localparam logic [FPS_W-1:0]  FPS_SCALE    = 27'd100000000;
   localparam logic [LIM_W-1:0]  US_PER_S     = 26'd1000000;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd2;
   localparam logic [OP_W-1:0] OP_EVICT_RD   = 4'd3;
   localparam logic [OP_W-1:0] OP_EVICT_SUB  = 4'd4;
   localparam logic [OP_W-1:0] OP_WRITE      = 4'd5;
   localparam logic [OP_W-1:0] OP_TRIM_RD    = 4'd6;
   localparam logic [OP_W-1:0] OP_TRIM_DROP  = 4'd7;
   localparam logic [OP_W-1:0] OP_SCAN_START = 4'd8;
   localparam logic [OP_W-1:0] OP_SCAN       = 4'd9;
   localparam logic [OP_W-1:0] OP_SUM        = 4'd10;
   localparam logic [OP_W-1:0] OP_MUL        = 4'd11;
   localparam logic [OP_W-1:0] OP_DIV_START  = 4'd12;
   localparam logic [OP_W-1:0] OP_DIV        = 4'd13;

   // divider jobs
   localparam logic [SEL_W-1:0] SEL_FPS    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_MEAN   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_LOW    = 2'd2;
   localparam logic [SEL_W-1:0] SEL_RECENT = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEL_W-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
      logic full;
      logic held_le1;
      logic trim_stop;
      logic scan_done;
      logic sum_done;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic               stats_valid;
      logic [FPS_W-1:0]   fps_x100;
      logic [TIME_W-1:0]  mean_frame_us;
      logic [FPS_W-1:0]   low_fps_x100;
      logic [TIME_W-1:0]  max_frame_us;
      logic [TOTAL_W-1:0] window_total_us;
      logic [CNT_W-1:0]   frame_count;
      logic [TIME_W-1:0]  recent_mean_us;
   } result_type;
endpackage
`default_nettype wire

>>> design/fts_ctrl.sv
// Sequencer for the frame time statistics core.
`default_nettype none
module fts_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  fts_pkg::status_type status,
   input  wire                 out_free,
   output logic                ready,
   output fts_pkg::cmd_type    cmd,
   output logic                out_load
);
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_EVICT_RD   = 4'd1;
   localparam logic [3:0] S_EVICT_SUB  = 4'd2;
   localparam logic [3:0] S_WRITE      = 4'd3;
   localparam logic [3:0] S_TRIM_RD    = 4'd4;
   localparam logic [3:0] S_TRIM_CHK   = 4'd5;
   localparam logic [3:0] S_SCAN_START = 4'd6;
   localparam logic [3:0] S_SCAN       = 4'd7;
   localparam logic [3:0] S_SUM        = 4'd8;
   localparam logic [3:0] S_MUL        = 4'd9;
   localparam logic [3:0] S_DIV_START  = 4'd10;
   localparam logic [3:0] S_DIV_RUN    = 4'd11;
   localparam logic [3:0] S_DONE       = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [fts_pkg::SEL_W-1:0]   sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd.op   = fts_pkg::OP_NONE;
      cmd.sel  = sel_ff;
      ready    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               if (status.in_zero) begin
                  cmd.op   = fts_pkg::OP_CLEAR;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = fts_pkg::OP_LOAD;
                  state_in = status.full ? S_EVICT_RD : S_WRITE;
               end
            end
         end
         S_EVICT_RD: begin
            cmd.op   = fts_pkg::OP_EVICT_RD;
            state_in = S_EVICT_SUB;
         end
         S_EVICT_SUB: begin
            cmd.op   = fts_pkg::OP_EVICT_SUB;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op   = fts_pkg::OP_WRITE;
            state_in = S_TRIM_RD;
         end
         S_TRIM_RD: begin
            if (status.held_le1) begin
               state_in = S_SCAN_START;
            end else begin
               cmd.op   = fts_pkg::OP_TRIM_RD;
               state_in = S_TRIM_CHK;
            end
         end
         S_TRIM_CHK: begin
            if (status.trim_stop) begin
               state_in = S_SCAN_START;
            end else begin
               cmd.op   = fts_pkg::OP_TRIM_DROP;
               state_in = S_TRIM_RD;
            end
         end
         S_SCAN_START: begin
            cmd.op   = fts_pkg::OP_SCAN_START;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = fts_pkg::OP_SCAN;
            if (status.scan_done) state_in = S_SUM;
         end
         S_SUM: begin
            if (status.sum_done) begin
               state_in = S_MUL;
            end else begin
               cmd.op = fts_pkg::OP_SUM;
            end
         end
         S_MUL: begin
            cmd.op   = fts_pkg::OP_MUL;
            sel_in   = fts_pkg::SEL_FPS;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.op   = fts_pkg::OP_DIV_START;
            state_in = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            cmd.op = fts_pkg::OP_DIV;
            if (status.div_done) begin
               if (sel_ff == fts_pkg::SEL_RECENT) begin
                  state_in = S_DONE;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= fts_pkg::SEL_FPS;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end
endmodule
`default_nettype wire

>>> design/fts_datapath.sv
// Datapath: frame ring memory, window registers, scan unit and shared divider.
`default_nettype none
module fts_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [fts_pkg::TIME_W-1:0]       frame_time_us,
   input  wire  [fts_pkg::CFG_W-1:0]        window_seconds,
   input  fts_pkg::cmd_type                 cmd,
   output fts_pkg::status_type              status,
   output fts_pkg::result_type              result
);
   logic [fts_pkg::TIME_W-1:0] mem [fts_pkg::CAPACITY];
   logic [fts_pkg::TIME_W-1:0] rdata_ff;
   logic [fts_pkg::PTR_W-1:0]  rd_addr;

   logic [fts_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [fts_pkg::CNT_W-1:0]   held_ff, held_in;
   logic [fts_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [fts_pkg::TIME_W-1:0]  t_ff, t_in;
   logic [fts_pkg::LIM_W-1:0]   lim_ff, lim_in;
   logic [fts_pkg::CFG_W-1:0]   secs;

   logic [fts_pkg::CNT_W-1:0]   issue_ff, issue_in;
   logic                        dval_ff, dval_in;
   logic [fts_pkg::TIME_W-1:0]  top_ff [fts_pkg::TOPN];
   logic [fts_pkg::TIME_W-1:0]  top_in [fts_pkg::TOPN];
   logic [fts_pkg::TOPN-1:0]    ge;
   logic [fts_pkg::RTOT_W-1:0]  rtot_ff, rtot_in;
   logic [fts_pkg::CNT_W-1:0]   rcnt_ff, rcnt_in;

   logic [fts_pkg::TOP_IDX_W-1:0] kval;
   logic [fts_pkg::TOP_IDX_W-1:0] sumc_ff, sumc_in;
   logic [fts_pkg::SLOW_W-1:0]    slow_ff, slow_in;
   logic [fts_pkg::DIV_W-1:0]     prod_n_ff, prod_n_in;
   logic [fts_pkg::DIV_W-1:0]     prod_k_ff, prod_k_in;

   logic [fts_pkg::DIV_W-1:0]     num_ff, num_in;
   logic [fts_pkg::TOTAL_W-1:0]   den_ff, den_in;
   logic [fts_pkg::TOTAL_W-1:0]   rem_ff, rem_in;
   logic [fts_pkg::TOTAL_W:0]     rem_sh;
   logic [fts_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;

   logic [fts_pkg::FPS_W-1:0]  fps_ff, fps_in, low_ff, low_in;
   logic [fts_pkg::TIME_W-1:0] mean_ff, mean_in, recent_ff, recent_in;

   // 1% count: ceil(held/100), at least one
   always_comb begin
      kval = '0;
      for (int j = 0; j < fts_pkg::TOPN; j++) begin
         kval = kval + fts_pkg::TOP_IDX_W'(held_ff > fts_pkg::CNT_W'(100 * j));
      end
   end

   // sorted insert keeps the largest frames, ties stay in arrival order
   always_comb begin
      for (int j = 0; j < fts_pkg::TOPN; j++) begin
         ge[j] = top_ff[j] >= rdata_ff;
      end
   end

   assign secs   = (window_seconds == '0) ? fts_pkg::CFG_W'(1) :
                   (window_seconds > fts_pkg::CFG_MAX) ? fts_pkg::CFG_MAX : window_seconds;
   assign rem_sh = {rem_ff, num_ff[fts_pkg::DIV_W-1]};

   always_comb begin
      unique case (cmd.op)
         fts_pkg::OP_EVICT_RD: rd_addr = wp_ff;
         fts_pkg::OP_TRIM_RD:  rd_addr = wp_ff - held_ff[fts_pkg::PTR_W-1:0];
         default:              rd_addr = wp_ff - issue_ff[fts_pkg::PTR_W-1:0] - 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == fts_pkg::OP_WRITE) mem[wp_ff] <= t_ff;
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      wp_in     = wp_ff;
      held_in   = held_ff;
      total_in  = total_ff;
      t_in      = t_ff;
      lim_in    = lim_ff;
      issue_in  = issue_ff;
      dval_in   = 1'b0;
      top_in    = top_ff;
      rtot_in   = rtot_ff;
      rcnt_in   = rcnt_ff;
      sumc_in   = sumc_ff;
      slow_in   = slow_ff;
      prod_n_in = prod_n_ff;
      prod_k_in = prod_k_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      fps_in    = fps_ff;
      low_in    = low_ff;
      mean_in   = mean_ff;
      recent_in = recent_ff;
      unique case (cmd.op)
         fts_pkg::OP_LOAD: begin
            t_in   = frame_time_us;
            lim_in = fts_pkg::LIM_W'(fts_pkg::LIM_W'(secs) * fts_pkg::US_PER_S);
         end
         fts_pkg::OP_CLEAR: begin
            wp_in    = '0;
            held_in  = '0;
            total_in = '0;
         end
         fts_pkg::OP_EVICT_SUB: begin
            total_in = total_ff - fts_pkg::TOTAL_W'(rdata_ff);
            held_in  = fts_pkg::CNT_W'(fts_pkg::CAPACITY - 1);
         end
         fts_pkg::OP_WRITE: begin
            total_in = total_ff + fts_pkg::TOTAL_W'(t_ff);
            wp_in    = wp_ff + 1'b1;
            held_in  = held_ff + 1'b1;
         end
         fts_pkg::OP_TRIM_DROP: begin
            total_in = total_ff - fts_pkg::TOTAL_W'(rdata_ff);
            held_in  = held_ff - 1'b1;
         end
         fts_pkg::OP_SCAN_START: begin
            issue_in = '0;
            rtot_in  = '0;
            rcnt_in  = '0;
            sumc_in  = '0;
            slow_in  = '0;
            for (int j = 0; j < fts_pkg::TOPN; j++) top_in[j] = '0;
         end
         fts_pkg::OP_SCAN: begin
            if (issue_ff < held_ff) begin
               issue_in = issue_ff + 1'b1;
               dval_in  = 1'b1;
            end
            if (dval_ff) begin
               for (int j = 0; j < fts_pkg::TOPN; j++) begin
                  if (ge[j])                  top_in[j] = top_ff[j];
                  else if (j == 0 || ge[j-1]) top_in[j] = rdata_ff;
                  else                        top_in[j] = top_ff[j-1];
               end
               if (rtot_ff < fts_pkg::RECENT_SPAN) begin
                  rtot_in = rtot_ff + fts_pkg::RTOT_W'(rdata_ff);
                  rcnt_in = rcnt_ff + 1'b1;
               end
            end
         end
         fts_pkg::OP_SUM: begin
            if (sumc_ff < kval) slow_in = slow_ff + fts_pkg::SLOW_W'(top_ff[sumc_ff]);
            sumc_in = sumc_ff + 1'b1;
         end
         fts_pkg::OP_MUL: begin
            prod_n_in = fts_pkg::DIV_W'(fts_pkg::DIV_W'(fts_pkg::FPS_SCALE)
                                        * fts_pkg::DIV_W'(held_ff));
            prod_k_in = fts_pkg::DIV_W'(fts_pkg::DIV_W'(fts_pkg::FPS_SCALE)
                                        * fts_pkg::DIV_W'(kval));
         end
         fts_pkg::OP_DIV_START: begin
            rem_in  = '0;
            dcnt_in = fts_pkg::DIV_CNT_W'(fts_pkg::DIV_W);
            unique case (cmd.sel)
               fts_pkg::SEL_FPS: begin
                  num_in = prod_n_ff;
                  den_in = total_ff;
               end
               fts_pkg::SEL_MEAN: begin
                  num_in = fts_pkg::DIV_W'(total_ff);
                  den_in = fts_pkg::TOTAL_W'(held_ff);
               end
               fts_pkg::SEL_LOW: begin
                  num_in = prod_k_ff;
                  den_in = fts_pkg::TOTAL_W'(slow_ff);
               end
               default: begin
                  num_in = fts_pkg::DIV_W'(rtot_ff);
                  den_in = fts_pkg::TOTAL_W'(rcnt_ff);
               end
            endcase
         end
         fts_pkg::OP_DIV: begin
            if (dcnt_ff != '0) begin
               // one restoring step per cycle, quotient shifts into num
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = fts_pkg::TOTAL_W'(rem_sh - {1'b0, den_ff});
                  num_in = {num_ff[fts_pkg::DIV_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[fts_pkg::TOTAL_W-1:0];
                  num_in = {num_ff[fts_pkg::DIV_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 1'b1;
            end else begin
               case (cmd.sel)
                  fts_pkg::SEL_FPS:  fps_in    = num_ff[fts_pkg::FPS_W-1:0];
                  fts_pkg::SEL_MEAN: mean_in   = num_ff[fts_pkg::TIME_W-1:0];
                  fts_pkg::SEL_LOW:  low_in    = num_ff[fts_pkg::FPS_W-1:0];
                  default:           recent_in = num_ff[fts_pkg::TIME_W-1:0];
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         held_ff  <= '0;
         total_ff <= '0;
         issue_ff <= '0;
         dval_ff  <= 1'b0;
         sumc_ff  <= '0;
         dcnt_ff  <= '0;
      end else begin
         wp_ff    <= wp_in;
         held_ff  <= held_in;
         total_ff <= total_in;
         issue_ff <= issue_in;
         dval_ff  <= dval_in;
         sumc_ff  <= sumc_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      lim_ff    <= lim_in;
      top_ff    <= top_in;
      rtot_ff   <= rtot_in;
      rcnt_ff   <= rcnt_in;
      slow_ff   <= slow_in;
      prod_n_ff <= prod_n_in;
      prod_k_ff <= prod_k_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      fps_ff    <= fps_in;
      low_ff    <= low_in;
      mean_ff   <= mean_in;
      recent_ff <= recent_in;
   end

   always_comb begin
      status.in_zero   = frame_time_us == '0;
      status.full      = held_ff == fts_pkg::CNT_W'(fts_pkg::CAPACITY);
      status.held_le1  = held_ff <= fts_pkg::CNT_W'(1);
      status.trim_stop = (total_ff - fts_pkg::TOTAL_W'(rdata_ff))
                         < fts_pkg::TOTAL_W'(lim_ff);
      status.scan_done = (issue_ff == held_ff) && !dval_ff;
      status.sum_done  = sumc_ff == fts_pkg::TOP_IDX_W'(fts_pkg::TOPN);
      status.div_done  = dcnt_ff == '0;
   end

   always_comb begin
      if (held_ff == '0) begin
         result = '0;
      end else begin
         result.stats_valid     = 1'b1;
         result.fps_x100        = fps_ff;
         result.mean_frame_us   = mean_ff;
         result.low_fps_x100    = low_ff;
         result.max_frame_us    = top_ff[0];
         result.window_total_us = total_ff;
         result.frame_count     = held_ff;
         result.recent_mean_us  = recent_ff;
      end
   end
endmodule
`default_nettype wire

>>> design/frame_time_window_stats_core.sv
// Top level of the frame time window statistics core.
// A zero item empties the history and goes straight to the result; any other item evicts
//   the oldest frame when the ring is full, then writes, trims, scans and divides.
// Throughput: one item at a time; the trim loop and the held-frame scan go through the
//   single memory read port, and four 37-step divides follow.
// Reset: synchronous, active high; empties the history and sets the window to 10 s.
// Frame memory is not cleared; only entries already written are ever used.
`default_nettype none
`include "assert_macros.svh"
module frame_time_window_stats_core (
   input  wire                            clock,
   input  wire                            reset,
   // input item
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [fts_pkg::TIME_W-1:0]     req_frame_time_us,
   // result item
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic                           rsp_stats_valid,
   output logic [fts_pkg::FPS_W-1:0]      rsp_fps_x100,
   output logic [fts_pkg::TIME_W-1:0]     rsp_mean_frame_us,
   output logic [fts_pkg::FPS_W-1:0]      rsp_low_fps_x100,
   output logic [fts_pkg::TIME_W-1:0]     rsp_max_frame_us,
   output logic [fts_pkg::TOTAL_W-1:0]    rsp_window_total_us,
   output logic [fts_pkg::CNT_W-1:0]      rsp_frame_count,
   output logic [fts_pkg::TIME_W-1:0]     rsp_recent_mean_us,
   // window length register
   input  wire                            csr_wr_en,
   input  wire  [fts_pkg::CFG_W-1:0]      csr_wr_data
);
   fts_pkg::cmd_type    cmd;
   fts_pkg::status_type status;
   fts_pkg::result_type result;
   fts_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [fts_pkg::CFG_W-1:0] secs_ff;
   logic                ready;
   logic                out_free;
   logic                out_load;

   // window length; the datapath clamps it to 1..60 s when an item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         secs_ff <= fts_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         secs_ff <= csr_wr_data;
      end
   end

   fts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .out_free  (out_free),
      .ready     (ready),
      .cmd       (cmd),
      .out_load  (out_load)
   );

   fts_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .frame_time_us  (req_frame_time_us),
      .window_seconds (secs_ff),
      .cmd            (cmd),
      .status         (status),
      .result         (result)
   );

   assign req_stall = !ready;

   // output register: a finished item waits here while the next one is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_ff <= result;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stats_valid     = rsp_ff.stats_valid;
   assign rsp_fps_x100        = rsp_ff.fps_x100;
   assign rsp_mean_frame_us   = rsp_ff.mean_frame_us;
   assign rsp_low_fps_x100    = rsp_ff.low_fps_x100;
   assign rsp_max_frame_us    = rsp_ff.max_frame_us;
   assign rsp_window_total_us = rsp_ff.window_total_us;
   assign rsp_frame_count     = rsp_ff.frame_count;
   assign rsp_recent_mean_us  = rsp_ff.recent_mean_us;

   `ASSERT_PROP(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall, "core took a second item before finishing the first")
   `ASSERT_NEVER(a_load_overwrites, clock, reset, out_load && rsp_valid_ff && rsp_stall, "result register overwritten while stalled")
   `ASSERT_NEVER(a_count_range, clock, reset, rsp_valid_ff && (rsp_ff.frame_count > fts_pkg::CNT_W'(fts_pkg::CAPACITY)), "frame count above capacity")
   `ASSERT_PROP(a_empty_zero, clock, reset, (rsp_valid_ff && !rsp_ff.stats_valid) |-> (rsp_ff.frame_count == '0 && rsp_ff.window_total_us == '0), "empty result carries data")
endmodule
`default_nettype wire
